FILE: src/pfa_pkg.sv
// Shared constants of the paged frame allocator: result status codes,
// request kinds, CSR indices and fixed field widths. No dependencies.
package pfa_pkg;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
   localparam logic [2:0] ST_NO_FRAMES  = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

   localparam logic KIND_CREATE = 1'b0;
   localparam logic KIND_LIST   = 1'b1;

   localparam logic [1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [1:0] CSR_FRAME_SIZE  = 2'd1;
   localparam logic [1:0] CSR_MAX_SIZE    = 2'd2;
   localparam logic [1:0] CSR_SEED        = 2'd3;

   localparam int DIV_W  = 20;
   localparam int DVS_W  = 13;
   localparam int SIZE_W = 19;

   typedef logic [15:0] lfsr_type;

endpackage

FILE: src/pfa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module pfa_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 640
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/paged_frame_allocator.sv
// Paged frame allocator: free-frame map, process table and page table RAM.
// Depends on pfa_pkg and pfa_ram.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | kind, process_id, process_size
//   rsp     | out       | rsp_valid/ready    | status, page_index, frame_number,
//           |           |                    | page_count, last
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One transaction at a time. A create counts free frames while dividing the
// size by the frame size, then per page runs a serial modulo of the LFSR by
// the frames left and a walk of the free map. A list searches the table entry
// by entry, then per page passes S_LREAD, S_LWAIT and S_LEMIT (RAM read).
// Reset marks every frame free, zeroes the process count and sets the LFSR to 1;
// no clearing pass. A stalled result holds the sequencer in its emit state.
module paged_frame_allocator #(
   parameter int FRAMES        = 64,
   parameter int MAX_PROCESSES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_process_id,
   input  logic [18:0] req_process_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_page_index,
   output logic [5:0]  rsp_frame_number,
   output logic [6:0]  rsp_page_count,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_wdata
);

   localparam int FIW = $clog2(FRAMES);
   localparam int SW  = $clog2(FRAMES + 1);
   localparam int PIW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int PCW = $clog2(MAX_PROCESSES + 1);
   localparam int RD  = MAX_PROCESSES * FRAMES;
   localparam int AW  = $clog2(RD);
   localparam int DCW = $clog2(pfa_pkg::DIV_W + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_COUNT  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_STEP   = 4'd4;
   localparam logic [3:0] S_MOD    = 4'd5;
   localparam logic [3:0] S_FIND   = 4'd6;
   localparam logic [3:0] S_AEMIT  = 4'd7;
   localparam logic [3:0] S_LSCAN  = 4'd8;
   localparam logic [3:0] S_LREAD  = 4'd9;
   localparam logic [3:0] S_LWAIT  = 4'd10;
   localparam logic [3:0] S_LEMIT  = 4'd11;
   localparam logic [3:0] S_EMIT1  = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [6:0]              frame_count_ff;
   logic [12:0]             frame_size_ff;
   logic [18:0]             max_size_ff;
   pfa_pkg::lfsr_type       lfsr_ff, lfsr_in, lfsr_next;
   logic [FRAMES-1:0]       free_map_ff, free_map_in;
   logic [15:0]             proc_id_ff [MAX_PROCESSES];
   logic [SW-1:0]           proc_pages_ff [MAX_PROCESSES];
   logic [PCW-1:0]          proc_count_ff, proc_count_in;
   logic                    tbl_we;

   logic [15:0]             pid_ff, pid_in;
   logic [18:0]             size_ff, size_in;
   logic [SW-1:0]           scan_ff, scan_in;
   logic [SW-1:0]           free_cnt_ff, free_cnt_in;
   logic [SW-1:0]           left_ff, left_in;
   logic [SW-1:0]           pages_ff, pages_in;
   logic [SW-1:0]           page_ff, page_in;
   logic [SW-1:0]           k_ff, k_in;
   logic [FIW-1:0]          frame_ff, frame_in;
   logic [PIW-1:0]          slot_ff, slot_in;
   logic [PCW-1:0]          p_ff, p_in;
   logic [2:0]              code_ff, code_in;

   logic [13:0]             div_rem_ff, div_rem_in;
   logic [pfa_pkg::DIV_W-1:0] div_quo_ff, div_quo_in;
   logic [12:0]             div_d_ff, div_d_in;
   logic [DCW-1:0]          div_cnt_ff, div_cnt_in;
   logic [13:0]             div_trial;
   logic                    div_start;
   logic [pfa_pkg::DIV_W-1:0] div_a;
   logic [12:0]             div_b;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [5:0]              rsp_page_index_ff, rsp_page_index_in;
   logic [5:0]              rsp_frame_number_ff, rsp_frame_number_in;
   logic [6:0]              rsp_page_count_ff, rsp_page_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [6:0]              lim;
   logic [12:0]             fs_eff;
   logic                    out_free;
   logic                    scan_ok;
   logic [FIW-1:0]          scan_idx;
   logic                    ram_we;
   logic [AW-1:0]           ram_addr;
   logic [FIW-1:0]          ram_rdata;

   assign lim       = (frame_count_ff > 7'(FRAMES)) ? 7'(FRAMES) : frame_count_ff;
   assign fs_eff    = (frame_size_ff == 13'd0) ? 13'd1 : frame_size_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_idx  = FIW'(scan_ff);
   assign scan_ok   = (scan_ff < SW'(FRAMES)) && (7'(scan_ff) < lim) && free_map_ff[scan_idx];
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign div_trial = {div_rem_ff[12:0], div_quo_ff[pfa_pkg::DIV_W-1]};
   assign ram_addr  = AW'(slot_ff) * AW'(FRAMES) + AW'(page_ff);

   pfa_ram #(
      .WIDTH(FIW),
      .DEPTH(RD)
   ) u_page_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(frame_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in            = state_ff;
      lfsr_in             = lfsr_ff;
      free_map_in         = free_map_ff;
      proc_count_in       = proc_count_ff;
      tbl_we              = 1'b0;
      pid_in              = pid_ff;
      size_in             = size_ff;
      scan_in             = scan_ff;
      free_cnt_in         = free_cnt_ff;
      left_in             = left_ff;
      pages_in            = pages_ff;
      page_in             = page_ff;
      k_in                = k_ff;
      frame_in            = frame_ff;
      slot_in             = slot_ff;
      p_in                = p_ff;
      code_in             = code_ff;
      div_start           = 1'b0;
      div_a               = '0;
      div_b               = 13'd1;
      ram_we              = 1'b0;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_status_in       = rsp_status_ff;
      rsp_page_index_in   = rsp_page_index_ff;
      rsp_frame_number_in = rsp_frame_number_ff;
      rsp_page_count_in   = rsp_page_count_ff;
      rsp_last_in         = rsp_last_ff;

      if (csr_we && csr_index == pfa_pkg::CSR_SEED) begin
         lfsr_in = (csr_wdata[15:0] == 16'd0) ? 16'd1 : csr_wdata[15:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pid_in   = req_process_id;
               size_in  = req_process_size;
               p_in     = '0;
               state_in = (req_kind == pfa_pkg::KIND_LIST) ? S_LSCAN : S_CHECK;
            end
         end
         S_CHECK: begin
            if (size_ff > max_size_ff) begin
               code_in  = pfa_pkg::ST_TOO_LARGE;
               state_in = S_EMIT1;
            end else begin
               div_start   = 1'b1;
               div_a       = pfa_pkg::DIV_W'(size_ff) + pfa_pkg::DIV_W'(fs_eff)
                             - pfa_pkg::DIV_W'(1);
               div_b       = fs_eff;
               scan_in     = '0;
               free_cnt_in = '0;
               state_in    = S_COUNT;
            end
         end
         S_COUNT: begin
            if (scan_ff < SW'(FRAMES)) begin
               scan_in = scan_ff + SW'(1);
               if (scan_ok) begin
                  free_cnt_in = free_cnt_ff + SW'(1);
               end
            end else if (div_cnt_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (div_quo_ff > pfa_pkg::DIV_W'(free_cnt_ff)) begin
               code_in  = pfa_pkg::ST_NO_FRAMES;
               state_in = S_EMIT1;
            end else if (proc_count_ff >= PCW'(MAX_PROCESSES)) begin
               code_in  = pfa_pkg::ST_TABLE_FULL;
               state_in = S_EMIT1;
            end else begin
               tbl_we        = 1'b1;
               pages_in      = SW'(div_quo_ff);
               slot_in       = PIW'(proc_count_ff);
               proc_count_in = proc_count_ff + PCW'(1);
               page_in       = '0;
               left_in       = free_cnt_ff;
               code_in       = pfa_pkg::ST_OK;
               state_in      = (div_quo_ff == '0) ? S_EMIT1 : S_STEP;
            end
         end
         S_STEP: begin
            lfsr_in   = lfsr_next;
            div_start = 1'b1;
            div_a     = pfa_pkg::DIV_W'(lfsr_next);
            div_b     = 13'(left_ff);
            state_in  = S_MOD;
         end
         S_MOD: begin
            if (div_cnt_ff == '0) begin
               k_in     = SW'(div_rem_ff);
               scan_in  = '0;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            scan_in = scan_ff + SW'(1);
            if (scan_ok) begin
               if (k_ff == '0) begin
                  free_map_in[scan_idx] = 1'b0;
                  frame_in              = scan_idx;
                  state_in              = S_AEMIT;
               end else begin
                  k_in = k_ff - SW'(1);
               end
            end
         end
         S_AEMIT: begin
            if (out_free) begin
               ram_we              = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_status_in       = pfa_pkg::ST_OK;
               rsp_page_index_in   = 6'(page_ff);
               rsp_frame_number_in = 6'(frame_ff);
               rsp_page_count_in   = 7'(pages_ff);
               rsp_last_in         = (page_ff + SW'(1) == pages_ff);
               page_in             = page_ff + SW'(1);
               left_in             = left_ff - SW'(1);
               state_in            = (page_ff + SW'(1) == pages_ff) ? S_IDLE : S_STEP;
            end
         end
         S_LSCAN: begin
            if (p_ff < proc_count_ff) begin
               if (proc_id_ff[PIW'(p_ff)] == pid_ff) begin
                  slot_in  = PIW'(p_ff);
                  pages_in = proc_pages_ff[PIW'(p_ff)];
                  page_in  = '0;
                  code_in  = pfa_pkg::ST_OK;
                  state_in = (proc_pages_ff[PIW'(p_ff)] == '0) ? S_EMIT1 : S_LREAD;
               end else begin
                  p_in = p_ff + PCW'(1);
               end
            end else begin
               code_in  = pfa_pkg::ST_NOT_FOUND;
               state_in = S_EMIT1;
            end
         end
         S_LREAD: begin
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            state_in = S_LEMIT;
         end
         S_LEMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = pfa_pkg::ST_OK;
               rsp_page_index_in   = 6'(page_ff);
               rsp_frame_number_in = 6'(ram_rdata);
               rsp_page_count_in   = 7'(pages_ff);
               rsp_last_in         = (page_ff + SW'(1) == pages_ff);
               page_in             = page_ff + SW'(1);
               state_in            = (page_ff + SW'(1) == pages_ff) ? S_IDLE : S_LREAD;
            end
         end
         S_EMIT1: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_status_in       = code_ff;
               rsp_page_index_in   = '0;
               rsp_frame_number_in = '0;
               rsp_page_count_in   = '0;
               rsp_last_in         = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (div_start) begin
         div_rem_in = '0;
         div_quo_in = div_a;
         div_d_in   = div_b;
         div_cnt_in = DCW'(pfa_pkg::DIV_W);
      end else if (div_cnt_ff != '0) begin
         div_d_in   = div_d_ff;
         div_cnt_in = div_cnt_ff - DCW'(1);
         if (div_trial >= {1'b0, div_d_ff}) begin
            div_rem_in = div_trial - {1'b0, div_d_ff};
            div_quo_in = {div_quo_ff[pfa_pkg::DIV_W-2:0], 1'b1};
         end else begin
            div_rem_in = div_trial;
            div_quo_in = {div_quo_ff[pfa_pkg::DIV_W-2:0], 1'b0};
         end
      end else begin
         div_rem_in = div_rem_ff;
         div_quo_in = div_quo_ff;
         div_d_in   = div_d_ff;
         div_cnt_in = div_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_count_ff <= 7'd64;
         frame_size_ff  <= 13'd256;
         max_size_ff    <= 19'd4096;
         lfsr_ff        <= 16'd1;
         free_map_ff    <= '1;
         proc_count_ff  <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lfsr_ff       <= lfsr_in;
         free_map_ff   <= free_map_in;
         proc_count_ff <= proc_count_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               pfa_pkg::CSR_FRAME_COUNT: frame_count_ff <= csr_wdata[6:0];
               pfa_pkg::CSR_FRAME_SIZE:  frame_size_ff  <= csr_wdata[12:0];
               pfa_pkg::CSR_MAX_SIZE:    max_size_ff    <= csr_wdata;
               pfa_pkg::CSR_SEED:        ;
               default:                  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         proc_id_ff[slot_in]    <= pid_ff;
         proc_pages_ff[slot_in] <= SW'(div_quo_ff);
      end
      pid_ff              <= pid_in;
      size_ff             <= size_in;
      scan_ff             <= scan_in;
      free_cnt_ff         <= free_cnt_in;
      left_ff             <= left_in;
      pages_ff            <= pages_in;
      page_ff             <= page_in;
      k_ff                <= k_in;
      frame_ff            <= frame_in;
      slot_ff             <= slot_in;
      p_ff                <= p_in;
      code_ff             <= code_in;
      div_rem_ff          <= div_rem_in;
      div_quo_ff          <= div_quo_in;
      div_d_ff            <= div_d_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_page_index_ff   <= rsp_page_index_in;
      rsp_frame_number_ff <= rsp_frame_number_in;
      rsp_page_count_ff   <= rsp_page_count_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_index   = rsp_page_index_ff;
   assign rsp_frame_number = rsp_frame_number_ff;
   assign rsp_page_count   = rsp_page_count_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   a_proc_count_bound: assert property (@(posedge clock) disable iff (reset)
      proc_count_ff <= PCW'(MAX_PROCESSES))
      else $error("process count beyond table depth");

   a_find_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIND |-> scan_ff < SW'(FRAMES))
      else $error("free frame walk ran off the map");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> div_cnt_ff == '0)
      else $error("divider busy while idle");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != pfa_pkg::ST_OK |-> rsp_last_ff)
      else $error("error result not marked last");

   a_alloc_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AEMIT && out_free |=> !free_map_ff[$past(frame_ff)])
      else $error("allocated frame still marked free");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench of paged_frame_allocator: create and list requests
// against an in-bench allocator predictor, with random handshake idling.
// Depends on pfa_pkg and the allocator RTL.

class page_map_board;
   // predictor state
   int unsigned n_frames, frame_bytes, size_limit, seed;
   bit          free_map [64];
   logic [15:0] table_ids [10];
   int unsigned table_pages [10];
   logic [5:0]  table_frames [10][64];
   int unsigned table_used;
   logic [15:0] shift_reg;
   logic [22:0] pending_results [$];
   int unsigned error_count;
   int unsigned result_count;

   function void clear_state();
      n_frames = 64; frame_bytes = 256; size_limit = 4096; seed = 1;
      foreach (free_map[i]) free_map[i] = 1'b1;
      table_used = 0;
      shift_reg = 16'd1;
      error_count = 0;
      result_count = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [18:0] value);
      case (idx)
         pfa_pkg::CSR_FRAME_COUNT: n_frames = value[6:0];
         pfa_pkg::CSR_FRAME_SIZE:  frame_bytes = value[12:0];
         pfa_pkg::CSR_MAX_SIZE:    size_limit = value;
         pfa_pkg::CSR_SEED: begin
            seed = value[15:0];
            shift_reg = (value[15:0] == 0) ? 16'd1 : value[15:0];
         end
         default: ;
      endcase
   endfunction

   function void push(logic [2:0] st, int unsigned pg, int unsigned fr,
                      int unsigned cnt, bit lst);
      pending_results.push_back({st, pg[5:0], fr[5:0], cnt[6:0], lst});
   endfunction

   function int unsigned free_total();
      int unsigned lim, n;
      lim = (n_frames > 64) ? 64 : n_frames;
      n = 0;
      for (int i = 0; i < lim; i++) if (free_map[i]) n++;
      return n;
   endfunction

   function int unsigned take_frame(int unsigned avail);
      int unsigned lim, k;
      logic fb;
      lim = (n_frames > 64) ? 64 : n_frames;
      fb = shift_reg[0] ^ shift_reg[2] ^ shift_reg[3] ^ shift_reg[5];
      shift_reg = {fb, shift_reg[15:1]};
      k = shift_reg % avail;
      for (int i = 0; i < lim; i++) begin
         if (free_map[i]) begin
            if (k == 0) begin
               free_map[i] = 1'b0;
               return i;
            end
            k--;
         end
      end
      return 0;
   endfunction

   function void note_request(logic kind, logic [15:0] pid, logic [18:0] size);
      int unsigned pages, avail, fs, slot, f;
      if (kind == pfa_pkg::KIND_LIST) begin
         for (int p = 0; p < table_used; p++) begin
            if (table_ids[p] == pid) begin
               pages = table_pages[p];
               if (pages == 0) begin
                  push(pfa_pkg::ST_OK, 0, 0, 0, 1);
                  return;
               end
               for (int i = 0; i < pages; i++)
                  push(pfa_pkg::ST_OK, i, table_frames[p][i], pages, i + 1 == pages);
               return;
            end
         end
         push(pfa_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
         return;
      end
      if (size > size_limit) begin
         push(pfa_pkg::ST_TOO_LARGE, 0, 0, 0, 1);
         return;
      end
      fs = (frame_bytes == 0) ? 1 : frame_bytes;
      pages = (size + fs - 1) / fs;
      avail = free_total();
      if (pages > avail) begin
         push(pfa_pkg::ST_NO_FRAMES, 0, 0, 0, 1);
         return;
      end
      if (table_used >= 10) begin
         push(pfa_pkg::ST_TABLE_FULL, 0, 0, 0, 1);
         return;
      end
      slot = table_used;
      table_ids[slot] = pid;
      table_pages[slot] = pages;
      table_used++;
      if (pages == 0) begin
         push(pfa_pkg::ST_OK, 0, 0, 0, 1);
         return;
      end
      for (int i = 0; i < pages; i++) begin
         f = take_frame(avail - i);
         table_frames[slot][i] = 6'(f);
         push(pfa_pkg::ST_OK, i, f, pages, i + 1 == pages);
      end
   endfunction

   function void check_result(logic [2:0] st, logic [5:0] pg, logic [5:0] fr,
                              logic [6:0] cnt, logic lst);
      logic [22:0] e;
      result_count++;
      if (pending_results.size() == 0) begin
         $error("unexpected result status=%0d page=%0d", st, pg);
         error_count++;
         return;
      end
      e = pending_results.pop_front();
      if (st !== e[22:20]) begin
         $error("status expected %0d actual %0d", e[22:20], st); error_count++;
      end
      if (pg !== e[19:14]) begin
         $error("page_index expected %0d actual %0d", e[19:14], pg); error_count++;
      end
      if (fr !== e[13:8]) begin
         $error("frame_number expected %0d actual %0d", e[13:8], fr); error_count++;
      end
      if (cnt !== e[7:1]) begin
         $error("page_count expected %0d actual %0d", e[7:1], cnt); error_count++;
      end
      if (lst !== e[0]) begin
         $error("last expected %0d actual %0d", e[0], lst); error_count++;
      end
   endfunction
endclass

module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = pfa_pkg::KIND_CREATE;
   logic [15:0] req_process_id = '0;
   logic [18:0] req_process_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_page_index;
   logic [5:0]  rsp_frame_number;
   logic [6:0]  rsp_page_count;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [18:0] csr_wdata = '0;

   page_map_board board;
   bit   idle_enable = 1'b1;
   bit   hold_off = 1'b0;
   bit   long_hold = 1'b0;
   int   quiet_cycles = 0;
   int   creates_sent = 0;
   int   lists_sent = 0;
   logic [15:0] known_ids [$];

   localparam int WATCHDOG_LIMIT = 60000;

   paged_frame_allocator i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_request(logic kind, logic [15:0] pid, logic [18:0] size);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_process_id   <= pid;
      req_process_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(kind, pid, size);
      if (kind == pfa_pkg::KIND_CREATE) begin
         creates_sent++;
         known_ids.push_back(pid);
      end else lists_sent++;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [18:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_request();
      logic [15:0] pid;
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4 && known_ids.size() != 0)
         send_request(pfa_pkg::KIND_LIST,
                      known_ids[$urandom_range(0, known_ids.size() - 1)],
                      19'($urandom));
      else if (r < 5)
         send_request(pfa_pkg::KIND_LIST, 16'($urandom), 19'($urandom));
      else begin
         pid = 16'($urandom);
         case ($urandom_range(0, 3))
            0: send_request(pfa_pkg::KIND_CREATE, pid, 19'($urandom));
            1: send_request(pfa_pkg::KIND_CREATE, pid, 19'($urandom_range(0, 8192)));
            default: send_request(pfa_pkg::KIND_CREATE, pid, 19'($urandom_range(0, 1024)));
         endcase
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off || long_hold) rsp_ready <= 1'b0;
      else if (!idle_enable) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   initial begin : stall_bursts
      int n;
      forever begin
         @(posedge clock);
         if (idle_enable && !hold_off && $urandom_range(0, 20) == 0) begin
            n = $urandom_range(1, 16);
            hold_off = 1'b1;
            repeat (n) @(posedge clock);
            hold_off = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset)
         board.check_result(rsp_status, rsp_page_index, rsp_frame_number,
                            rsp_page_count, rsp_last);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress, %0d results outstanding",
                  board.pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      board = new();
      board.clear_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults
      send_request(pfa_pkg::KIND_LIST, 16'hFFFF, '0);
      send_request(pfa_pkg::KIND_CREATE, 16'h0000, 19'd0);
      send_request(pfa_pkg::KIND_LIST, 16'h0000, 19'h7FFFF);
      send_request(pfa_pkg::KIND_CREATE, 16'hFFFF, 19'd4097);
      send_request(pfa_pkg::KIND_CREATE, 16'h1234, 19'd4096);
      send_request(pfa_pkg::KIND_LIST, 16'h1234, '0);
      send_request(pfa_pkg::KIND_CREATE, 16'h1234, 19'd1);
      send_request(pfa_pkg::KIND_LIST, 16'h1234, '0);
      drain();

      // directed: small memory, zero frame size, zero seed, full table
      write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'd3);
      write_csr(pfa_pkg::CSR_FRAME_SIZE, 19'd0);
      write_csr(pfa_pkg::CSR_MAX_SIZE, 19'h7FFFF);
      write_csr(pfa_pkg::CSR_SEED, 19'd0);
      send_request(pfa_pkg::KIND_CREATE, 16'hAAAA, 19'd4);
      send_request(pfa_pkg::KIND_CREATE, 16'h5555, 19'd2);
      send_request(pfa_pkg::KIND_CREATE, 16'h5555, 19'd1);
      send_request(pfa_pkg::KIND_LIST, 16'h5555, '0);
      repeat (4) send_request(pfa_pkg::KIND_CREATE, 16'($urandom), 19'd0);
      send_request(pfa_pkg::KIND_CREATE, 16'h0001, 19'd0);
      send_request(pfa_pkg::KIND_CREATE, 16'h0002, 19'd0);
      send_request(pfa_pkg::KIND_LIST, 16'h0002, '0);
      drain();
      write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'd0);
      send_request(pfa_pkg::KIND_CREATE, 16'h0003, 19'd1);
      drain();

      // random phases across register settings; the table fills after ten
      // creates and the directed tests have already filled it, so no create
      // here succeeds and creates now mostly report a full table
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'd127);
               write_csr(pfa_pkg::CSR_FRAME_SIZE, 19'd4096);
               write_csr(pfa_pkg::CSR_MAX_SIZE, 19'd262144);
               write_csr(pfa_pkg::CSR_SEED, 19'd65535);
            end
            1: begin
               write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'd64);
               write_csr(pfa_pkg::CSR_FRAME_SIZE, 19'd1);
               write_csr(pfa_pkg::CSR_MAX_SIZE, 19'd0);
            end
            2: begin
               write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'd1);
               write_csr(pfa_pkg::CSR_FRAME_SIZE, 19'd8191);
               write_csr(pfa_pkg::CSR_SEED, 19'($urandom_range(1, 65535)));
            end
            default: begin
               write_csr(pfa_pkg::CSR_FRAME_COUNT, 19'($urandom_range(0, 127)));
               write_csr(pfa_pkg::CSR_FRAME_SIZE, 19'($urandom_range(0, 8191)));
               write_csr(pfa_pkg::CSR_MAX_SIZE, 19'($urandom));
               write_csr(pfa_pkg::CSR_SEED, 19'($urandom));
               write_csr(pfa_pkg::CSR_SEED, 19'($urandom));
            end
         endcase
         if (phase == 5) idle_enable = 1'b0;
         if (phase == 3) begin
            fork
               begin
                  long_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  long_hold = 1'b0;
               end
               repeat (6) random_request();
            join
         end
         repeat (20) random_request();
         drain();
      end

      $display("covered %0d creates and %0d lists, %0d results checked",
               creates_sent, lists_sent, board.result_count);
      if (board.error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
